FILE: rtl/core/fcpi_pkg.sv
// ----------------------------------------------------------------------------
// fcpi_pkg
// Shared types and constants of the first-come palette indexer.
// ----------------------------------------------------------------------------
package fcpi_pkg;

  // Palette geometry
  localparam int N_CELLS      = 256;
  localparam int IDX_W        = 8;
  localparam int CNT_W        = 9;
  localparam int COLOR_W      = 32;
  localparam int LOG2_W       = 4;
  localparam int CAP_LOG2_MIN = 1;
  localparam int CAP_LOG2_MAX = 8;
  localparam logic [LOG2_W-1:0] LOG2_RESET = LOG2_W'(8);

  // Input beat
  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               image_start;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [IDX_W-1:0] color_index;
    logic             added_entry;
    logic             palette_full_fallback;
    logic [CNT_W-1:0] entries_used;
  } out_beat_t;

  // Probe that walks the cell row
  typedef struct packed {
    logic               valid;
    logic [COLOR_W-1:0] color;
  } probe_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic               kill;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [COLOR_W-1:0] wr_color;
  } row_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } fcpi_state_t;

endpackage

FILE: rtl/core/fcpi_cell.sv
// ----------------------------------------------------------------------------
// fcpi_cell
// One palette entry: holds a color, compares the passing probe against it
// and hands the probe on to the next cell.
// ----------------------------------------------------------------------------
module fcpi_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [fcpi_pkg::IDX_W-1:0] cell_idx_i,
  input  fcpi_pkg::row_ctl_t      ctl_i,
  input  fcpi_pkg::probe_t        probe_i,
  output fcpi_pkg::probe_t        probe_o,
  output logic                    hit_o
);
  import fcpi_pkg::*;

  logic               pv_r;
  logic [COLOR_W-1:0] pc_r;
  logic [COLOR_W-1:0] color_r;

  // Advance the probe; drop it when the sequencer resolves the search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= probe_i.valid && !ctl_i.kill;
    end
  end

  always_ff @(posedge clk) begin
    pc_r <= probe_i.color;
  end

  // Store a newly appended color
  always_ff @(posedge clk) begin
    if (ctl_i.wr_en && (ctl_i.wr_idx == cell_idx_i)) begin
      color_r <= ctl_i.wr_color;
    end
  end

  assign probe_o.valid = pv_r;
  assign probe_o.color = pc_r;
  assign hit_o         = pv_r && (pc_r == color_r);

endmodule

FILE: rtl/core/fcpi_ctrl.sv
// ----------------------------------------------------------------------------
// fcpi_ctrl
// Sequencer: takes pixel beats, launches the probe into the cell row, tracks
// its position, resolves hit, append or fallback, and holds the result beat.
// ----------------------------------------------------------------------------
module fcpi_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fcpi_pkg::in_beat_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fcpi_pkg::out_beat_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fcpi_pkg::LOG2_W-1:0] cfg_data,
  output fcpi_pkg::probe_t           probe_o,
  output fcpi_pkg::row_ctl_t         ctl_o,
  input  logic                       hit_any_i
);
  import fcpi_pkg::*;

  fcpi_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic [LOG2_W-1:0]  log2_r;
  out_beat_t          pend_r, pend_nxt;
  out_beat_t          out_r;
  logic               out_valid_r;

  logic [LOG2_W-1:0]  lg;
  logic [CNT_W-1:0]   cap;
  logic [CNT_W-1:0]   miss_used;
  logic               room;
  out_beat_t          miss_beat;
  logic               out_free;

  // Capacity from the size register, clamped to the supported range
  always_comb begin
    lg = log2_r;
    if (lg < LOG2_W'(CAP_LOG2_MIN)) lg = LOG2_W'(CAP_LOG2_MIN);
    if (lg > LOG2_W'(CAP_LOG2_MAX)) lg = LOG2_W'(CAP_LOG2_MAX);
    cap = CNT_W'(1) << lg;
    if (cap > CNT_W'(N_CELLS)) cap = CNT_W'(N_CELLS);
  end

  // Miss handling: append while there is room, otherwise fall back to zero
  always_comb begin
    miss_used = (state_r == ST_IDLE) ? CNT_W'(0) : count_r;
    room      = miss_used < cap;
    miss_beat.color_index           = room ? miss_used[IDX_W-1:0] : '0;
    miss_beat.added_entry           = room;
    miss_beat.palette_full_fallback = !room;
    miss_beat.entries_used          = room ? (miss_used + CNT_W'(1)) : miss_used;
  end

  assign out_free = !out_valid_r || out_ready;

  // Next state and outputs
  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    count_nxt       = count_r;
    color_nxt       = color_r;
    pend_nxt        = pend_r;
    in_ready        = 1'b0;
    probe_o.valid   = 1'b0;
    probe_o.color   = in_data.pixel_color;
    ctl_o.kill      = 1'b0;
    ctl_o.wr_en     = 1'b0;
    ctl_o.wr_idx    = miss_used[IDX_W-1:0];
    ctl_o.wr_color  = color_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          color_nxt = in_data.pixel_color;
          if (in_data.image_start || (count_r == '0)) begin
            // Empty palette or new image: append at entry zero right away
            ctl_o.wr_en    = 1'b1;
            ctl_o.wr_color = in_data.pixel_color;
            count_nxt      = miss_beat.entries_used;
            pend_nxt       = miss_beat;
            state_nxt      = ST_DONE;
          end else begin
            probe_o.valid = 1'b1;
            pos_nxt       = '0;
            state_nxt     = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (hit_any_i) begin
          ctl_o.kill                     = 1'b1;
          pend_nxt.color_index           = pos_r;
          pend_nxt.added_entry           = 1'b0;
          pend_nxt.palette_full_fallback = 1'b0;
          pend_nxt.entries_used          = count_r;
          state_nxt                      = ST_DONE;
        end else if (({1'b0, pos_r} + CNT_W'(1)) == count_r) begin
          ctl_o.kill  = 1'b1;
          ctl_o.wr_en = room;
          count_nxt   = miss_beat.entries_used;
          pend_nxt    = miss_beat;
          state_nxt   = ST_DONE;
        end else begin
          pos_nxt = pos_r + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      log2_r      <= LOG2_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid) begin
        log2_r <= cfg_data;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    color_r <= color_nxt;
    pend_r  <= pend_nxt;
    if ((state_r == ST_DONE) && out_free) begin
      out_r <= pend_r;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/core/first_come_palette_indexer.sv
// ----------------------------------------------------------------------------
// first_come_palette_indexer
// Maps 32-bit colors to palette indices, appending unseen colors in order.
// ----------------------------------------------------------------------------
// Each pixel beat is looked up by a probe that walks a row of 256 palette
// cells, one cell per clock, starting at entry 0 and stopping at the first
// match or after the last filled entry. A miss appends while there is
// room and otherwise falls back to index zero; a pixel on an empty palette
// (or with image_start set) is appended at entry zero without a walk. The
// walk of the probe down the cell row sets the rate; one pixel is in flight
// at a time, while the previous result may still wait in the output
// register. The configuration write is always ready and should only be
// issued while no pixel is in flight.
// ----------------------------------------------------------------------------
module first_come_palette_indexer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fcpi_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fcpi_pkg::out_beat_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fcpi_pkg::LOG2_W-1:0] cfg_data
);
  import fcpi_pkg::*;

  probe_t             probe_inj;
  probe_t             probe_q [N_CELLS];
  row_ctl_t           row_ctl;
  logic [N_CELLS-1:0] hit_vec;

  fcpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .probe_o   (probe_inj),
    .ctl_o     (row_ctl),
    .hit_any_i (|hit_vec)
  );

  // Cell row: each cell takes the probe from its left neighbor
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      fcpi_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_idx_i (IDX_W'(i)),
        .ctl_i      (row_ctl),
        .probe_i    (probe_inj),
        .probe_o    (probe_q[i]),
        .hit_o      (hit_vec[i])
      );
    end else begin : g_body
      fcpi_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_idx_i (IDX_W'(i)),
        .ctl_i      (row_ctl),
        .probe_i    (probe_q[i-1]),
        .probe_o    (probe_q[i]),
        .hit_o      (hit_vec[i])
      );
    end
  end

endmodule

FILE: rtl/core/fcpi_chk.sv
// ----------------------------------------------------------------------------
// fcpi_chk
// Port-level checks of the palette indexer, bound to the top level.
// ----------------------------------------------------------------------------
module fcpi_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input fcpi_pkg::out_beat_t out_data
);
  import fcpi_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Fallback forces index zero
  a_fallback_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.palette_full_fallback |-> out_data.color_index == '0)
    else $error("fallback with nonzero index");

  // Append and fallback exclude each other
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.added_entry && out_data.palette_full_fallback))
    else $error("append and fallback both set");

  // An appended color lands at the last filled entry
  a_append_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.added_entry |->
      out_data.entries_used == ({1'b0, out_data.color_index} + CNT_W'(1)))
    else $error("appended index does not match entry count");

endmodule

bind first_come_palette_indexer fcpi_chk u_fcpi_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
